FILE: hdl/bpru_pkg.sv
// bpru_pkg: shared types and constants for the bitmap pixel row unpacker
// no dependencies; used by the interfaces, the output buffer and the top level

package bpru_pkg;

  // configuration register field widths
  localparam int SIZE_W     = 13;
  localparam int CFG_ADDR_W = 8;
  localparam int INDEX_W    = 24;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TOP_DOWN     = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 8'd3;

  // pixel format codes
  localparam logic FMT_BPP24 = 1'b0;
  localparam logic FMT_BPP32 = 1'b1;

  // byte position of the final byte of a pixel in each format
  localparam logic [1:0] LAST_BYTE_BPP24 = 2'd2;
  localparam logic [1:0] LAST_BYTE_BPP32 = 2'd3;

  // alpha value filled in for 24-bit pixels
  localparam logic [7:0] OPAQUE = 8'hFF;

  // one finished pixel
  typedef struct packed {
    logic [7:0]         slot_zero;
    logic [7:0]         slot_one;
    logic [7:0]         slot_two;
    logic [7:0]         slot_three;
    logic [INDEX_W-1:0] out_index;
    logic               last_pixel;
  } pixel_t;

endpackage

FILE: hdl/bpru_if.sv
// bpru_if: valid/ready channel interfaces of the bitmap pixel row unpacker
// depends on bpru_pkg for field widths

// raw pixel-array bytes, one byte per beat
interface bpru_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// finished pixels, one pixel per beat
interface bpru_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  slot_zero;
  logic [7:0]                  slot_one;
  logic [7:0]                  slot_two;
  logic [7:0]                  slot_three;
  logic [bpru_pkg::INDEX_W-1:0] out_index;
  logic                        last_pixel;

  modport source (output valid, output slot_zero, output slot_one, output slot_two,
                  output slot_three, output out_index, output last_pixel, input ready);
  modport sink   (input valid, input slot_zero, input slot_one, input slot_two,
                  input slot_three, input out_index, input last_pixel, output ready);
endinterface

// configuration register writes
interface bpru_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpru_pkg::CFG_ADDR_W-1:0] index;
  logic [bpru_pkg::SIZE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/bpru_out_fifo.sv
// bpru_out_fifo: two-entry pixel buffer driving the output channel
// depends on bpru_pkg (pixel_t) and bpru_pixel_if

module bpru_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bpru_pkg::pixel_t push_data,
  output logic             full,
  bpru_pixel_if.source     pixels
);

  bpru_pkg::pixel_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop  = pixels.valid && pixels.ready;
  assign full = (count == 2'd2);

  // storage, written at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // head entry to the channel
  assign pixels.valid      = (count != 2'd0);
  assign pixels.slot_zero  = entries[rd_ptr].slot_zero;
  assign pixels.slot_one   = entries[rd_ptr].slot_one;
  assign pixels.slot_two   = entries[rd_ptr].slot_two;
  assign pixels.slot_three = entries[rd_ptr].slot_three;
  assign pixels.out_index  = entries[rd_ptr].out_index;
  assign pixels.last_pixel = entries[rd_ptr].last_pixel;

endmodule

FILE: hdl/bmp_pixel_row_unpacker.sv
// bmp_pixel_row_unpacker: bitmap pixel-array byte stream to indexed four-byte pixels
// depends on bpru_pkg, bpru_if (byte, pixel and cfg interfaces) and bpru_out_fifo
//
// Usage:
//   cfg    - register writes (index, data): image_width, image_height, top_down,
//            pixel_format. Always ready; write only while the block is idle.
//   bytes  - raw pixel-array bytes in file order, one byte per beat, row padding
//            included. 24-bit pixels take three beats, 32-bit pixels four.
//   pixels - one beat per completed pixel: four slots, its top-down row-major
//            out_index and last_pixel on the final pixel of the frame.
// Throughput is one byte per cycle while the output buffer has room. A byte is held
// in the input register, is decoded by a single pass of logic (one 13x13 multiply
// and a 24-bit add for the index) and is written to a two-entry output buffer,
// from which the pixel that the byte completes is offered on pixels.
// When the receiver stalls, the output buffer absorbs two pixels, after which
// the input register holds and bytes.ready drops until a pixel is taken.
// Reset (synchronous) empties the buffer, clears all counters and sets the
// registers to width 1, height 1, bottom-up rows, 24-bit pixels.

module bmp_pixel_row_unpacker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic         clk,
  input  logic         rst,
  bpru_cfg_if.sink     cfg,
  bpru_byte_if.sink    bytes,
  bpru_pixel_if.source pixels
);

  localparam int SW     = bpru_pkg::SIZE_W;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CNT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W  = ((CNT_W > SW) ? CNT_W : SW) + 1;
  localparam int PROD_W = 2 * SW;
  localparam logic [SW-1:0] SIZE_ALL = {SW{1'b1}};
  localparam logic [SW-1:0] WIDTH_CAP  = (MAX_WIDTH > int'(SIZE_ALL)) ? SIZE_ALL
                                                                      : SW'(MAX_WIDTH);
  localparam logic [SW-1:0] HEIGHT_CAP = (MAX_HEIGHT > int'(SIZE_ALL)) ? SIZE_ALL
                                                                       : SW'(MAX_HEIGHT);

  // configuration registers
  logic [SW-1:0] image_width;
  logic [SW-1:0] image_height;
  logic          top_down;
  logic          pixel_format;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       fifo_full;

  // decode state
  logic [1:0]       byte_position, byte_position_next;
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [1:0]       padding_left, padding_left_next;
  logic [23:0]      held_bytes, held_bytes_next;

  // decode datapath
  logic [SW-1:0]     w_eff, h_eff;
  logic [1:0]        last_byte;
  logic              pad_drop;
  logic              complete;
  logic [CMP_W-1:0]  col_wide, row_wide, w_wide, h_wide;
  logic              col_last, row_last;
  logic [SW-1:0]     col_idx, row_idx, out_row;
  logic [PROD_W-1:0] row_product;
  logic              push;
  bpru_pkg::pixel_t  result;

  // configuration writes; indexes past the list are ignored
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SW'(1);
      image_height <= SW'(1);
      top_down     <= 1'b0;
      pixel_format <= bpru_pkg::FMT_BPP24;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bpru_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        bpru_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data;
        bpru_pkg::REG_TOP_DOWN:     top_down     <= cfg.data[0];
        bpru_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // input register, drains whenever the output buffer has room
  assign advance     = in_valid && !fifo_full;
  assign bytes.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.data_byte;
    end
  end

  // effective sizes: zero reads as one, capped at the maximum
  always_comb begin
    if (image_width == '0) begin
      w_eff = SW'(1);
    end else if (image_width > WIDTH_CAP) begin
      w_eff = WIDTH_CAP;
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = SW'(1);
    end else if (image_height > HEIGHT_CAP) begin
      h_eff = HEIGHT_CAP;
    end else begin
      h_eff = image_height;
    end
  end

  // byte classification
  assign last_byte = (pixel_format == bpru_pkg::FMT_BPP32) ? bpru_pkg::LAST_BYTE_BPP32
                                                           : bpru_pkg::LAST_BYTE_BPP24;
  assign pad_drop  = (padding_left != 2'd0);
  assign complete  = !pad_drop && (byte_position >= last_byte);

  // position compares, counters past the current size clamp to the last line
  assign col_wide = CMP_W'(column_count);
  assign row_wide = CMP_W'(row_count);
  assign w_wide   = CMP_W'(w_eff);
  assign h_wide   = CMP_W'(h_eff);
  assign col_last = (col_wide >= w_wide - CMP_W'(1));
  assign row_last = (row_wide >= h_wide - CMP_W'(1));
  assign col_idx  = (col_wide < w_wide) ? col_wide[SW-1:0] : w_eff - SW'(1);
  assign row_idx  = (row_wide < h_wide) ? row_wide[SW-1:0] : h_eff - SW'(1);

  // output index: row (mirrored for bottom-up images) times width plus column
  assign out_row     = top_down ? row_idx : (h_eff - SW'(1) - row_idx);
  assign row_product = PROD_W'(out_row) * PROD_W'(w_eff);

  always_comb begin
    if (pixel_format == bpru_pkg::FMT_BPP32) begin
      result.slot_zero = held_bytes[7:0];
      result.slot_one  = held_bytes[15:8];
      result.slot_two  = held_bytes[23:16];
    end else begin
      result.slot_zero = bpru_pkg::OPAQUE;
      result.slot_one  = held_bytes[7:0];
      result.slot_two  = held_bytes[15:8];
    end
    result.slot_three = in_byte;
    result.out_index  = row_product[bpru_pkg::INDEX_W-1:0]
                        + bpru_pkg::INDEX_W'(col_idx);
    result.last_pixel = col_last && row_last;
  end

  assign push = advance && complete;

  // next decode state
  always_comb begin
    byte_position_next = byte_position;
    column_count_next  = column_count;
    row_count_next     = row_count;
    padding_left_next  = padding_left;
    held_bytes_next    = held_bytes;
    if (advance) begin
      if (pad_drop) begin
        padding_left_next = padding_left - 2'd1;
      end else if (!complete) begin
        unique case (byte_position)
          2'd0:    held_bytes_next[7:0]   = held_bytes[7:0] | in_byte;
          2'd1:    held_bytes_next[15:8]  = held_bytes[15:8] | in_byte;
          2'd2:    held_bytes_next[23:16] = held_bytes[23:16] | in_byte;
          default: held_bytes_next = held_bytes;
        endcase
        byte_position_next = byte_position + 2'd1;
      end else begin
        byte_position_next = 2'd0;
        held_bytes_next    = '0;
        if (col_last) begin
          column_count_next = '0;
          padding_left_next = (pixel_format == bpru_pkg::FMT_BPP32) ? 2'd0 : w_eff[1:0];
          row_count_next    = row_last ? '0 : row_count + ROW_W'(1);
        end else begin
          column_count_next = column_count + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      column_count  <= '0;
      row_count     <= '0;
      padding_left  <= '0;
      held_bytes    <= '0;
    end else begin
      byte_position <= byte_position_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      padding_left  <= padding_left_next;
      held_bytes    <= held_bytes_next;
    end
  end

  // output buffer
  bpru_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (fifo_full),
    .pixels    (pixels)
  );

  // padding is only ever dropped between pixels
  a_pad_between_pixels: assert property (@(posedge clk) disable iff (rst)
    padding_left != 2'd0 |-> byte_position == 2'd0)
    else $error("row padding pending in the middle of a pixel");

  // a dropped pad byte leaves the pixel assembly alone
  a_pad_keeps_position: assert property (@(posedge clk) disable iff (rst)
    advance && pad_drop |=> byte_position == $past(byte_position)
                            && held_bytes == $past(held_bytes))
    else $error("pad byte disturbed pixel assembly");

  // the final pixel of a frame restarts the counters
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    push && result.last_pixel |=> row_count == '0 && column_count == '0
                                  && byte_position == 2'd0)
    else $error("counters not restarted after last pixel");

endmodule
